// ===== hdl/irp_pkg.sv =====
// Package for the interval room partition unit: payload structs, FSM states,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package irp_pkg;

  localparam int unsigned MaxActivitiesDefault = 16;
  localparam int unsigned IdW   = 8;
  localparam int unsigned TimeW = 16;
  localparam int unsigned RoomW = 5;

  typedef struct packed {
    logic [IdW-1:0]   act_id;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [IdW-1:0]   act_id_res;
    logic [RoomW-1:0] room;
    logic [RoomW-1:0] room_count;
    logic             last_result;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_OPEN,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // write the input beat into the store
    logic sort_init;  // start insertion sort
    logic sort_step;  // one compare/swap or advance step
    logic open_init;  // clear rooms, start the outer sweep
    logic open_step;  // examine the outer entry
    logic scan_step;  // examine one inner entry
    logic emit_init;  // start the result index
    logic emit_step;  // a result beat was taken
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_done;
    logic open_done;
    logic scan_done;
    logic emit_last;
  } status_t;

endpackage

// ===== hdl/interval_room_partition_unit.sv =====
// Interval room partition unit: loads one activity beat per cycle, then sorts
// by end/start time with an insertion sort (one compare/swap per cycle) and
// sweeps rooms greedily, then emits one result beat per loaded activity, one
// per cycle unless stalled. Input is stalled from the last beat until the final
// result is taken. Reset is asynchronous, active low; the store contents are
// not reset.
`timescale 1ns / 1ps

module interval_room_partition_unit #(
  parameter int unsigned MaxActivities = irp_pkg::MaxActivitiesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  irp_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output irp_pkg::out_beat_t out_data_o
);
  import irp_pkg::*;

  cmd_t    cmd;
  status_t status;

  irp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  irp_dpath #(.MaxActivities(MaxActivities)) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_beat_o (out_data_o)
  );

  // Input and output are never open at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(out_valid_o && !in_stall_o))
    else $error("input and output open together");

  // Every room on a result lies within the room count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.room != '0 && out_data_o.room <= out_data_o.room_count))
    else $error("room out of range");

  // After the final result is taken, input reopens.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_result) |=> !in_stall_o)
    else $error("input did not reopen");

endmodule

// ===== hdl/irp_ctrl.sv =====
// Controller FSM for the interval room partition unit.
// Depends on irp_pkg.
`timescale 1ns / 1ps

module irp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  irp_pkg::status_t  status_i,
  output irp_pkg::cmd_t     cmd_o
);
  import irp_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.sort_init = 1'b1;
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (status_i.sort_done) begin
          cmd_o.open_init = 1'b1;
          state_d = ST_OPEN;
        end else begin
          cmd_o.sort_step = 1'b1;
        end
      end
      ST_OPEN: begin
        if (status_i.open_done) begin
          cmd_o.emit_init = 1'b1;
          state_d = ST_EMIT;
        end else begin
          cmd_o.open_step = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_OPEN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/irp_dpath.sv =====
// Datapath for the interval room partition unit: activity store, sort and
// room sweep indices, result beat. Depends on irp_pkg.
`timescale 1ns / 1ps

module irp_dpath #(
  parameter int unsigned MaxActivities = irp_pkg::MaxActivitiesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irp_pkg::in_beat_t  in_beat_i,
  input  irp_pkg::cmd_t      cmd_i,
  output irp_pkg::status_t   status_o,
  output irp_pkg::out_beat_t out_beat_o
);
  import irp_pkg::*;

  localparam int unsigned IdxW = (MaxActivities > 1) ? $clog2(MaxActivities) : 1;
  localparam int unsigned CntW = $clog2(MaxActivities + 1);

  // Store entries; read at fixed neighbor pairs chosen by the sort index.
  logic [TimeW-1:0] st_start_q [MaxActivities];
  logic [TimeW-1:0] st_end_q   [MaxActivities];
  logic [IdW-1:0]   st_id_q    [MaxActivities];
  logic [RoomW-1:0] room_q     [MaxActivities];

  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  i_q;      // outer index (sort pass / sweep / emit)
  logic [CntW-1:0]  k_q;      // inner index (sort sink / scan)
  logic [RoomW-1:0] rooms_q;
  logic [TimeW-1:0] latest_q;

  logic [IdxW-1:0] ia, ka, km1;
  logic            k_pos, swap;

  assign ia    = i_q[IdxW-1:0];
  assign ka    = k_q[IdxW-1:0];
  assign km1   = ka - IdxW'(1);
  assign k_pos = (k_q != '0);

  // Entry k-1 comes strictly after entry k.
  always_comb begin
    if (st_end_q[km1] != st_end_q[ka]) begin
      swap = st_end_q[km1] > st_end_q[ka];
    end else begin
      swap = st_start_q[km1] > st_start_q[ka];
    end
  end

  assign status_o.sort_done = (i_q >= count_q);
  assign status_o.open_done = (i_q >= count_q);
  assign status_o.scan_done = (k_q >= count_q);
  assign status_o.emit_last = (i_q + CntW'(1) == count_q);

  // Store writes and swaps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CntW'(MaxActivities))) begin
      st_start_q[count_q[IdxW-1:0]] <= in_beat_i.start_time;
      st_end_q[count_q[IdxW-1:0]]   <= in_beat_i.end_time;
      st_id_q[count_q[IdxW-1:0]]    <= in_beat_i.act_id;
    end else if (cmd_i.sort_step && k_pos && swap) begin
      st_start_q[km1] <= st_start_q[ka];
      st_start_q[ka]  <= st_start_q[km1];
      st_end_q[km1]   <= st_end_q[ka];
      st_end_q[ka]    <= st_end_q[km1];
      st_id_q[km1]    <= st_id_q[ka];
      st_id_q[ka]     <= st_id_q[km1];
    end
  end

  // Room marks, cleared at the start of each sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < MaxActivities; n++) room_q[n] <= '0;
    end else if (cmd_i.open_init) begin
      for (int n = 0; n < MaxActivities; n++) room_q[n] <= '0;
    end else if (cmd_i.open_step && room_q[ia] == '0) begin
      room_q[ia] <= rooms_q + RoomW'(1);
    end else if (cmd_i.scan_step && room_q[ka] == '0 && st_start_q[ka] > latest_q) begin
      room_q[ka] <= rooms_q;
    end
  end

  // Indices and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      i_q      <= '0;
      k_q      <= '0;
      rooms_q  <= '0;
      latest_q <= '0;
    end else begin
      if (cmd_i.load && (count_q < CntW'(MaxActivities))) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.sort_init) begin
        i_q <= CntW'(1);
        k_q <= CntW'(1);
      end else if (cmd_i.sort_step) begin
        if (k_pos && swap) begin
          k_q <= k_q - CntW'(1);
        end else begin
          i_q <= i_q + CntW'(1);
          k_q <= i_q + CntW'(1);
        end
      end else if (cmd_i.open_init) begin
        i_q     <= '0;
        rooms_q <= '0;
      end else if (cmd_i.open_step) begin
        if (room_q[ia] == '0) begin
          rooms_q  <= rooms_q + RoomW'(1);
          latest_q <= st_end_q[ia];
          k_q      <= i_q + CntW'(1);
        end else begin
          k_q <= count_q;
        end
        i_q <= i_q + CntW'(1);
      end else if (cmd_i.scan_step) begin
        if (room_q[ka] == '0 && st_start_q[ka] > latest_q) begin
          latest_q <= st_end_q[ka];
        end
        k_q <= k_q + CntW'(1);
      end else if (cmd_i.emit_init) begin
        i_q <= '0;
      end else if (cmd_i.emit_step) begin
        i_q <= i_q + CntW'(1);
        if (status_o.emit_last) begin
          count_q <= '0;
        end
      end
    end
  end

  // Result beat for the current emit index.
  assign out_beat_o.act_id_res  = st_id_q[ia];
  assign out_beat_o.room        = room_q[ia];
  assign out_beat_o.room_count  = rooms_q;
  assign out_beat_o.last_result = status_o.emit_last;

endmodule

// ===== dv/tb.sv =====
// Testbench for the interval room partition unit: drives activity sets, predicts
// room assignments with a greedy partitioning model and checks every result beat.
// Depends on irp_pkg and interval_room_partition_unit.
`timescale 1ns / 1ps

module tb;
  import irp_pkg::*;

  localparam int unsigned NumAct = 16;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  interval_room_partition_unit #(.MaxActivities(NumAct)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: activities of the set being loaded.
  logic [IdW-1:0]   set_id[NumAct];
  logic [TimeW-1:0] set_start[NumAct];
  logic [TimeW-1:0] set_end[NumAct];
  int unsigned      set_fill;
  out_beat_t        room_results_q[$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned sets_solved;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Stores one accepted beat; a beat with last solves the set and queues results.
  task automatic predict_rooms(input in_beat_t b);
    logic [TimeW-1:0] ts, te, latest;
    logic [IdW-1:0]   tid;
    logic [RoomW-1:0] room_of[NumAct];
    logic [RoomW-1:0] opened;
    int k;
    out_beat_t r;
    if (set_fill < NumAct) begin
      set_id[set_fill] = b.act_id;
      set_start[set_fill] = b.start_time;
      set_end[set_fill] = b.end_time;
      set_fill++;
    end
    if (!b.last) return;
    // Stable insertion sort by end, then start.
    for (int i = 1; i < set_fill; i++) begin
      k = i;
      while (k > 0 && (set_end[k-1] > set_end[k] ||
             (set_end[k-1] == set_end[k] && set_start[k-1] > set_start[k]))) begin
        ts = set_start[k-1]; te = set_end[k-1]; tid = set_id[k-1];
        set_start[k-1] = set_start[k]; set_end[k-1] = set_end[k];
        set_id[k-1] = set_id[k];
        set_start[k] = ts; set_end[k] = te; set_id[k] = tid;
        k--;
      end
    end
    // Greedy sweep: each unassigned activity opens a room.
    opened = '0;
    for (int i = 0; i < NumAct; i++) room_of[i] = '0;
    for (int i = 0; i < set_fill; i++) begin
      if (room_of[i] != '0) continue;
      opened++;
      room_of[i] = opened;
      latest = set_end[i];
      for (int j = i + 1; j < set_fill; j++) begin
        if (room_of[j] == '0 && set_start[j] > latest) begin
          room_of[j] = opened;
          latest = set_end[j];
        end
      end
    end
    for (int i = 0; i < set_fill; i++) begin
      r.act_id_res = set_id[i];
      r.room = room_of[i];
      r.room_count = opened;
      r.last_result = (i + 1 == set_fill);
      room_results_q.push_back(r);
    end
    set_fill = 0;
    sets_solved++;
  endtask

  // Sender: presents one beat and holds it until it is accepted.
  task automatic send_activity(input in_beat_t b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_rooms(b);
  endtask

  function automatic in_beat_t make_beat(input logic [IdW-1:0] id, input logic [TimeW-1:0] s,
                                         input logic [TimeW-1:0] e, input logic l);
    in_beat_t b;
    b.act_id = id; b.start_time = s; b.end_time = e; b.last = l;
    return b;
  endfunction

  // Receiver: random stall and checking against the oldest expectation.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (room_results_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = room_results_q.pop_front();
          if (out_data_o.act_id_res !== want.act_id_res)
            report_mismatch($sformatf("act_id_res %0d, want %0d",
                                      out_data_o.act_id_res, want.act_id_res));
          if (out_data_o.room !== want.room)
            report_mismatch($sformatf("room %0d, want %0d", out_data_o.room, want.room));
          if (out_data_o.room_count !== want.room_count)
            report_mismatch($sformatf("room_count %0d, want %0d",
                                      out_data_o.room_count, want.room_count));
          if (out_data_o.last_result !== want.last_result)
            report_mismatch($sformatf("last_result %0b, want %0b",
                                      out_data_o.last_result, want.last_result));
        end
      end
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Directed table; a row with a typed room check carries want_room != 0.
  typedef struct {
    in_beat_t         beat;
    logic [RoomW-1:0] want_room;
    logic [RoomW-1:0] want_count;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input logic [IdW-1:0] id, input logic [TimeW-1:0] s,
                         input logic [TimeW-1:0] e, input logic l,
                         input logic [RoomW-1:0] wr, input logic [RoomW-1:0] wc);
    dir_row_t row;
    row.beat = make_beat(id, s, e, l);
    row.want_room = wr;
    row.want_count = wc;
    dir_rows.push_back(row);
  endtask

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned n;
    int unsigned wait_cycles;
    logic [TimeW-1:0] base, s;
    logic dense;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    set_fill = 0;
    errors = 0;
    results_seen = 0;
    sets_solved = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single activity at the extremes: one room, one room used.
    add_row(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd1, 5'd1);
    add_row(8'h00, 16'h0000, 16'h0000, 1'b1, 5'd1, 5'd1);
    // Touching intervals need two rooms (start must exceed the latest end).
    add_row(8'h01, 16'h0000, 16'h0005, 1'b0, 5'd0, 5'd0);
    add_row(8'h02, 16'h0005, 16'h0009, 1'b1, 5'd0, 5'd0);
    // Full ties keep arrival order; reversed ends get sorted.
    add_row(8'hA5, 16'h0010, 16'h0020, 1'b0, 5'd0, 5'd0);
    add_row(8'h5A, 16'h0010, 16'h0020, 1'b0, 5'd0, 5'd0);
    add_row(8'h33, 16'h0030, 16'h0008, 1'b0, 5'd0, 5'd0);
    add_row(8'h44, 16'h0021, 16'hFFFF, 1'b1, 5'd0, 5'd0);
    // Full store: seventeen beats, the dropped one carries last.
    for (int i = 0; i < NumAct; i++)
      add_row(8'(i * 17), 16'(i * 3), 16'(i * 3 + 1), 1'b0, 5'd0, 5'd0);
    add_row(8'hEE, 16'h1234, 16'h4321, 1'b1, 5'd0, 5'd0);

    foreach (dir_rows[i]) begin
      send_activity(dir_rows[i].beat);
      if (dir_rows[i].want_room != '0) begin
        if (room_results_q.size() == 0 ||
            room_results_q[$].room != dir_rows[i].want_room ||
            room_results_q[$].room_count != dir_rows[i].want_count)
          report_mismatch($sformatf("directed row %0d predicted rooms differ", i));
      end
    end

    // Random sets under changing idle and stall pressure.
    sent = 0;
    phase = 0;
    while (sent < 480) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      phase++;
      repeat (6) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(NumAct + 2, NumAct) :
                                       $urandom_range(8, 1);
        dense = 1'($urandom_range(1));
        base = 16'($urandom);
        for (int i = 0; i < n; i++) begin
          if (dense) begin
            s = 16'($urandom_range(40)) + base;
            send_activity(make_beat(8'($urandom), s, s + 16'($urandom_range(20)),
                                    i == n - 1));
          end else begin
            send_activity(make_beat(8'($urandom), 16'($urandom), 16'($urandom),
                                    i == n - 1));
          end
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then a short quiet period for stray beats.
    wait_cycles = 0;
    while (room_results_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);

    $display("Ran %0d sets, %0d result beats checked, under four idle/stall mixes.",
             sets_solved, results_seen);
    if (errors == 0 && room_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (room_results_q.size() != 0)
        $display("%0d expected results never arrived", room_results_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
